// File: src/ppu_pkg.sv
`default_nettype none
// -----------------------------------------------------------------------------
// ppu_pkg
// Shared types and constants of the packed palette entry unpacker.
// -----------------------------------------------------------------------------
package ppu_pkg;

   localparam int WORD_BITS  = 64;
   localparam int ENTRY_BITS = 16;
   localparam int MAX_WIDTH  = 16;
   localparam int CSR_BITS   = 5;

   localparam logic KIND_PALETTE = 1'b0;
   localparam logic KIND_DATA    = 1'b1;

   localparam logic REG_BITS_PER_ENTRY = 1'b0;
   localparam logic REG_PALETTE_ENABLE = 1'b1;

   typedef logic [ENTRY_BITS-1:0] entry_type;

   typedef struct packed {
      logic      en;
      logic [7:0] idx;
      entry_type data;
   } pal_wr_type;

   typedef struct packed {
      logic      en;
      entry_type entry;
   } pal_rd_type;

   function automatic entry_type low_mask(input logic [4:0] n);
      logic [ENTRY_BITS:0] m;
      m = ((ENTRY_BITS+1)'(1) << n) - (ENTRY_BITS+1)'(1);
      return m[ENTRY_BITS-1:0];
   endfunction

endpackage
`default_nettype wire

// File: src/ppu_palette.sv
`default_nettype none
// -----------------------------------------------------------------------------
// ppu_palette
// Palette memory: one write port, one registered read port; entries beyond
// the depth read as zero.
// -----------------------------------------------------------------------------
module ppu_palette #(
   parameter int DEPTH = 256
) (
   input  wire                       clock,
   input  wire ppu_pkg::pal_wr_type  wr,
   input  wire ppu_pkg::pal_rd_type  rd,
   output ppu_pkg::entry_type        rd_value
);

   localparam int AW = $clog2(DEPTH);

   ppu_pkg::entry_type palette_mem [DEPTH];
   ppu_pkg::entry_type rd_value_ff;
   logic [15:0]        wr_idx_wide;

   assign wr_idx_wide = {8'd0, wr.idx};

   always_ff @(posedge clock) begin
      if (wr.en && (wr_idx_wide < 16'(DEPTH))) begin
         palette_mem[wr_idx_wide[AW-1:0]] <= wr.data;
      end
      if (rd.en) begin
         if (rd.entry < 16'(DEPTH)) begin
            rd_value_ff <= palette_mem[rd.entry[AW-1:0]];
         end else begin
            rd_value_ff <= '0;
         end
      end
   end

   assign rd_value = rd_value_ff;

endmodule
`default_nettype wire

// File: src/packed_palette_entry_unpacker.sv
`default_nettype none
// -----------------------------------------------------------------------------
// packed_palette_entry_unpacker
// Unpacks 64-bit words LSB first into entries of 1..16 bits, carries partial
// entries across words and maps each entry through a 16-bit palette when enabled.
// -----------------------------------------------------------------------------
// Each entry goes from the shared shifter into the s1 register, with the palette
// read registered alongside, and then into the response register. The input is
// not ready while a word is unpacked; one entry per cycle leaves the shifter
// unless the response path stalls. Reset clears the carried bits, the entry count
// and the pipeline and loads bits_per_entry = 4, palette_enable = 1; palette kept.
module packed_palette_entry_unpacker #(
   parameter int SECTION_ENTRIES = 4096,
   parameter int PALETTE_DEPTH   = 256
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire         req_kind,
   input  wire  [7:0]  req_palette_index,
   input  wire  [15:0] req_palette_value,
   input  wire  [63:0] req_data_word,
   input  wire         req_start_section,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic [11:0] rsp_block_type,
   output logic [3:0]  rsp_block_variant,
   output logic [11:0] rsp_entry_number,
   output logic        rsp_last_in_item,
   output logic        rsp_section_done,
   input  wire         csr_we,
   input  wire         csr_index,
   input  wire  [4:0]  csr_wdata
);

   localparam int ECW = $clog2(SECTION_ENTRIES + 1);
   localparam int RW  = $clog2(ppu_pkg::WORD_BITS + 1);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   logic                 state_ff, state_in;
   logic [4:0]           bpe_ff, bpe_in;
   logic                 pal_en_ff, pal_en_in;
   logic [63:0]          word_ff, word_in;
   logic [RW-1:0]        rem_ff, rem_in;
   ppu_pkg::entry_type   carry_bits_ff, carry_bits_in;
   logic [4:0]           carry_count_ff, carry_count_in;
   logic [ECW-1:0]       count_ff, count_in;

   logic                 s1_valid_ff, s1_valid_in;
   ppu_pkg::entry_type   s1_entry_ff, s1_entry_in;
   logic [ECW-1:0]       s1_number_ff, s1_number_in;
   logic                 s1_last_ff, s1_last_in;
   logic                 s1_done_ff, s1_done_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   ppu_pkg::entry_type   rsp_value_ff, rsp_value_in;
   logic [ECW-1:0]       rsp_number_ff, rsp_number_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic                 rsp_done_ff, rsp_done_in;

   logic                 req_accept;
   logic                 adv2;
   logic                 s1_load_ok;
   logic                 emit;
   logic [4:0]           width_eff;
   logic [4:0]           need;
   logic [63:0]          shifted;
   ppu_pkg::entry_type   part;
   ppu_pkg::entry_type   entry;
   logic [31:0]          part_pos;
   logic [RW-1:0]        rem_after;
   logic [ECW-1:0]       count_next;
   logic [ECW-1:0]       count_base;
   logic                 full_next;
   logic                 last_rem;
   logic                 step_last;
   ppu_pkg::pal_wr_type  pal_wr;
   ppu_pkg::pal_rd_type  pal_rd;
   ppu_pkg::entry_type   pal_value;

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_accept = req_valid && req_ready;
   assign adv2       = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign s1_load_ok = !s1_valid_ff || adv2;
   assign emit       = (state_ff == ST_RUN) && s1_load_ok;

   always_comb begin
      if (bpe_ff == 5'd0) begin
         width_eff = 5'd1;
      end else if (bpe_ff > 5'(ppu_pkg::MAX_WIDTH)) begin
         width_eff = 5'(ppu_pkg::MAX_WIDTH);
      end else begin
         width_eff = bpe_ff;
      end
   end

   // shared shift unit: one entry per step
   assign need       = width_eff - carry_count_ff;
   assign shifted    = word_ff >> need;
   assign part       = word_ff[15:0] & ppu_pkg::low_mask(need);
   assign part_pos   = {16'd0, part} << carry_count_ff;
   assign entry      = carry_bits_ff | part_pos[15:0];
   assign rem_after  = rem_ff - RW'(need);
   assign count_next = count_ff + ECW'(1);
   assign full_next  = (count_next >= ECW'(SECTION_ENTRIES));
   assign last_rem   = (rem_after < RW'(width_eff));
   assign step_last  = full_next || last_rem;
   assign count_base = req_start_section ? '0 : count_ff;

   assign pal_wr.en   = req_accept && (req_kind == ppu_pkg::KIND_PALETTE);
   assign pal_wr.idx  = req_palette_index;
   assign pal_wr.data = req_palette_value;
   assign pal_rd.en    = emit;
   assign pal_rd.entry = entry;

   ppu_palette #(
      .DEPTH(PALETTE_DEPTH)
   ) u_palette (
      .clock   (clock),
      .wr      (pal_wr),
      .rd      (pal_rd),
      .rd_value(pal_value)
   );

   always_comb begin
      state_in       = state_ff;
      bpe_in         = bpe_ff;
      pal_en_in      = pal_en_ff;
      word_in        = word_ff;
      rem_in         = rem_ff;
      carry_bits_in  = carry_bits_ff;
      carry_count_in = carry_count_ff;
      count_in       = count_ff;
      s1_valid_in    = s1_valid_ff;
      s1_entry_in    = s1_entry_ff;
      s1_number_in   = s1_number_ff;
      s1_last_in     = s1_last_ff;
      s1_done_in     = s1_done_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_value_in   = rsp_value_ff;
      rsp_number_in  = rsp_number_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_done_in    = rsp_done_ff;

      if (csr_we && (csr_index == ppu_pkg::REG_BITS_PER_ENTRY)) begin
         bpe_in         = csr_wdata;
         carry_bits_in  = '0;
         carry_count_in = '0;
      end
      if (csr_we && (csr_index == ppu_pkg::REG_PALETTE_ENABLE)) begin
         pal_en_in = csr_wdata[0];
      end

      if (req_accept && (req_kind == ppu_pkg::KIND_DATA)) begin
         word_in = req_data_word;
         rem_in  = RW'(ppu_pkg::WORD_BITS);
         if (req_start_section) begin
            carry_bits_in  = '0;
            carry_count_in = '0;
            count_in       = '0;
         end
         // drop the word when the section is already full
         if (count_base >= ECW'(SECTION_ENTRIES)) begin
            state_in = ST_IDLE;
         end else begin
            state_in = ST_RUN;
         end
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (adv2) begin
         rsp_valid_in  = 1'b1;
         rsp_value_in  = pal_en_ff ? pal_value : s1_entry_ff;
         rsp_number_in = s1_number_ff;
         rsp_last_in   = s1_last_ff;
         rsp_done_in   = s1_done_ff;
         s1_valid_in   = 1'b0;
      end

      if (emit) begin
         s1_valid_in  = 1'b1;
         s1_entry_in  = entry;
         s1_number_in = count_ff;
         s1_last_in   = step_last;
         s1_done_in   = full_next;
         word_in      = shifted;
         rem_in       = rem_after;
         count_in     = count_next;
         if (step_last && !full_next) begin
            // hold the tail of the word as a partial entry
            carry_bits_in  = shifted[15:0] & ppu_pkg::low_mask(rem_after[4:0]);
            carry_count_in = rem_after[4:0];
         end else begin
            carry_bits_in  = '0;
            carry_count_in = '0;
         end
         state_in = step_last ? ST_IDLE : ST_RUN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         bpe_ff         <= 5'd4;
         pal_en_ff      <= 1'b1;
         carry_bits_ff  <= '0;
         carry_count_ff <= '0;
         count_ff       <= '0;
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         bpe_ff         <= bpe_in;
         pal_en_ff      <= pal_en_in;
         carry_bits_ff  <= carry_bits_in;
         carry_count_ff <= carry_count_in;
         count_ff       <= count_in;
         s1_valid_ff    <= s1_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      word_ff       <= word_in;
      rem_ff        <= rem_in;
      s1_entry_ff   <= s1_entry_in;
      s1_number_ff  <= s1_number_in;
      s1_last_ff    <= s1_last_in;
      s1_done_ff    <= s1_done_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_number_ff <= rsp_number_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_done_ff   <= rsp_done_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_block_type    = rsp_value_ff[15:4];
   assign rsp_block_variant = rsp_value_ff[3:0];
   assign rsp_entry_number  = 12'(rsp_number_ff);
   assign rsp_last_in_item  = rsp_last_ff;
   assign rsp_section_done  = rsp_done_ff;

endmodule
`default_nettype wire

// File: tb/tb_packed_palette_entry_unpacker.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_packed_palette_entry_unpacker
// Self-checking bench for the packed palette entry unpacker. A directed table
// covers palette writes, width extremes, out-of-depth entries, carries across
// words and width changes. Random rounds follow under several idling mixes,
// and then a section is filled to its end. An internal unpacker predicts each
// entry the table does not list, and each output is checked field by field.
// -----------------------------------------------------------------------------
module tb_packed_palette_entry_unpacker;

   localparam int SECTION_SIZE = 4096;
   localparam int PAL_DEPTH    = 256;
   localparam int SETTLE       = 100;
   localparam logic signed [7:0] PREDICT = -8'sd1;

   typedef enum logic {ROW_CSR, ROW_ITEM} row_op_type;

   typedef struct packed {
      logic [11:0] btype;
      logic [3:0]  variant;
      logic [11:0] number;
      logic        last;
      logic        done;
   } entry_rsp_type;

   typedef struct packed {
      row_op_type        op;
      logic              csr_idx;
      logic [4:0]        csr_val;
      logic              kind;
      logic [7:0]        pidx;
      logic [15:0]       pval;
      logic [63:0]       word;
      logic              start;
      logic signed [7:0] typed_n;
      logic [15:0]       typed_state;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_kind = ppu_pkg::KIND_PALETTE;
   logic [7:0]  req_palette_index = '0;
   logic [15:0] req_palette_value = '0;
   logic [63:0] req_data_word = '0;
   logic        req_start_section = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [11:0] rsp_block_type;
   logic [3:0]  rsp_block_variant;
   logic [11:0] rsp_entry_number;
   logic        rsp_last_in_item;
   logic        rsp_section_done;
   logic        csr_we = 1'b0;
   logic        csr_index = ppu_pkg::REG_BITS_PER_ENTRY;
   logic [4:0]  csr_wdata = '0;

   logic [15:0]   pal_mem [PAL_DEPTH];
   logic [15:0]   carry_q = '0;
   int            carry_n = 0;
   logic [12:0]   sect_cnt = '0;
   logic [4:0]    width_reg = 5'd4;
   logic          pal_on = 1'b1;
   entry_rsp_type pending_entries [$];
   stim_row_type  stim_rows [$];

   int gap_pct = 0;
   int stall_pct = 0;
   int mismatches = 0;
   int items_sent = 0;
   int data_words = 0;
   int pal_writes = 0;
   int entries_checked = 0;

   packed_palette_entry_unpacker #(
      .SECTION_ENTRIES(SECTION_SIZE),
      .PALETTE_DEPTH(PAL_DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_kind(req_kind),
      .req_palette_index(req_palette_index),
      .req_palette_value(req_palette_value),
      .req_data_word(req_data_word),
      .req_start_section(req_start_section),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_block_type(rsp_block_type),
      .rsp_block_variant(rsp_block_variant),
      .rsp_entry_number(rsp_entry_number),
      .rsp_last_in_item(rsp_last_in_item),
      .rsp_section_done(rsp_section_done),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #1 clock = ~clock;

   function automatic void expect_entry(input entry_rsp_type e);
      pending_entries = {pending_entries, e};
   endfunction

   function automatic void add_row(input stim_row_type s);
      stim_rows = {stim_rows, s};
   endfunction

   function automatic void unpack_word(input logic [63:0] word, input logic start,
                                       input bit record);
      int            w;
      int            pos;
      int            need;
      logic [15:0]   mask;
      logic [15:0]   part;
      logic [15:0]   entry;
      logic [15:0]   mapped;
      bit            held;
      entry_rsp_type r;
      if (start) begin
         carry_q = '0;
         carry_n = 0;
         sect_cnt = '0;
      end
      if (sect_cnt >= SECTION_SIZE) return;
      w = (width_reg == 5'd0) ? 1 : (width_reg > 5'd16) ? 16 : int'(width_reg);
      pos = 0;
      held = 1'b0;
      r = '0;
      while (pos < 64) begin
         need = w - carry_n;
         if (64 - pos >= need) begin
            mask = 16'((32'd1 << need) - 32'd1);
            part = 16'(word >> pos) & mask;
            entry = carry_q | 16'(part << carry_n);
            if (!pal_on) mapped = entry;
            else if (entry < PAL_DEPTH) mapped = pal_mem[entry[7:0]];
            else mapped = '0;
            pos += need;
            carry_q = '0;
            carry_n = 0;
            if (held && record) expect_entry(r);
            r.btype = mapped[15:4];
            r.variant = mapped[3:0];
            r.number = sect_cnt[11:0];
            r.last = 1'b0;
            sect_cnt++;
            r.done = (sect_cnt >= SECTION_SIZE);
            held = 1'b1;
            if (r.done) break;
         end else begin
            mask = 16'((32'd1 << (64 - pos)) - 32'd1);
            part = 16'(word >> pos) & mask;
            carry_q = carry_q | 16'(part << carry_n);
            carry_n += 64 - pos;
            break;
         end
      end
      if (held && record) begin
         r.last = 1'b1;
         expect_entry(r);
      end
   endfunction

   function automatic stim_row_type csr_row(input logic idx, input logic [4:0] val);
      stim_row_type s;
      s = '0;
      s.op = ROW_CSR;
      s.csr_idx = idx;
      s.csr_val = val;
      s.typed_n = PREDICT;
      return s;
   endfunction

   function automatic stim_row_type pal_row(input logic [7:0] idx, input logic [15:0] val);
      stim_row_type s;
      s = '0;
      s.op = ROW_ITEM;
      s.kind = ppu_pkg::KIND_PALETTE;
      s.pidx = idx;
      s.pval = val;
      s.typed_n = PREDICT;
      return s;
   endfunction

   function automatic stim_row_type word_row(input logic [63:0] w, input logic start,
                                             input logic signed [7:0] n,
                                             input logic [15:0] st);
      stim_row_type s;
      s = '0;
      s.op = ROW_ITEM;
      s.kind = ppu_pkg::KIND_DATA;
      s.word = w;
      s.start = start;
      s.typed_n = n;
      s.typed_state = st;
      return s;
   endfunction

   task automatic set_idling(input int gap, input int stall);
      gap_pct = gap;
      stall_pct = stall;
   endtask

   task automatic wait_drained(input int extra);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_entries.size() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [4:0] val);
      wait_drained(SETTLE);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == ppu_pkg::REG_BITS_PER_ENTRY) begin
         width_reg = val;
         carry_q = '0;
         carry_n = 0;
      end else begin
         pal_on = val[0];
      end
   endtask

   task automatic send_item(input logic kind, input logic [7:0] pidx,
                            input logic [15:0] pval, input logic [63:0] word,
                            input logic start, input logic signed [7:0] typed_n,
                            input logic [15:0] typed_state);
      entry_rsp_type r;
      while ($urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_palette_index <= pidx;
      req_palette_value <= pval;
      req_data_word <= word;
      req_start_section <= start;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
      if (kind == ppu_pkg::KIND_PALETTE) begin
         pal_mem[pidx] = pval;
         pal_writes++;
      end else begin
         data_words++;
         unpack_word(word, start, typed_n < 0);
         for (int i = 0; i < typed_n; i++) begin
            r.btype = typed_state[15:4];
            r.variant = typed_state[3:0];
            r.number = 12'(i);
            r.last = (i == typed_n - 1);
            r.done = 1'b0;
            expect_entry(r);
         end
      end
   endtask

   task automatic send_data(input logic [63:0] word, input logic start);
      send_item(ppu_pkg::KIND_DATA, 8'($urandom), 16'($urandom), word, start, PREDICT,
                '0);
   endtask

   task automatic send_pal(input logic [7:0] idx, input logic [15:0] val);
      send_item(ppu_pkg::KIND_PALETTE, idx, val, {$urandom, $urandom}, 1'($urandom),
                PREDICT, '0);
   endtask

   always @(posedge clock) begin : rsp_check
      entry_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_entries.size() == 0) begin
            $error("unexpected entry: block_type %0h block_variant %0h entry_number %0d",
                   rsp_block_type, rsp_block_variant, rsp_entry_number);
            mismatches++;
         end else begin
            want = pending_entries.pop_front();
            entries_checked++;
            if (rsp_block_type !== want.btype) begin
               $error("block_type: expected %0h, got %0h", want.btype, rsp_block_type);
               mismatches++;
            end
            if (rsp_block_variant !== want.variant) begin
               $error("block_variant: expected %0h, got %0h", want.variant,
                      rsp_block_variant);
               mismatches++;
            end
            if (rsp_entry_number !== want.number) begin
               $error("entry_number: expected %0d, got %0d", want.number, rsp_entry_number);
               mismatches++;
            end
            if (rsp_last_in_item !== want.last) begin
               $error("last_in_item: expected %0b, got %0b", want.last, rsp_last_in_item);
               mismatches++;
            end
            if (rsp_section_done !== want.done) begin
               $error("section_done: expected %0b, got %0b", want.done, rsp_section_done);
               mismatches++;
            end
         end
      end
      rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
   end

   initial begin
      #2_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      logic [4:0] width_pick;
      int         pick;
      foreach (pal_mem[i]) pal_mem[i] = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      add_row(pal_row(8'd0, 16'hABC5));
      add_row(pal_row(8'd15, 16'h0010));
      add_row(pal_row(8'd255, 16'hFFFF));
      add_row(pal_row(8'd1, 16'h5A3C));
      add_row(word_row(64'h0, 1'b1, 8'sd16, 16'hABC5));
      add_row(word_row('1, 1'b1, 8'sd16, 16'h0010));
      add_row(word_row(64'h1111_1111_1111_1110, 1'b0, PREDICT, '0));
      add_row(csr_row(ppu_pkg::REG_BITS_PER_ENTRY, 5'd8));
      add_row(word_row('1, 1'b1, 8'sd8, 16'hFFFF));
      add_row(csr_row(ppu_pkg::REG_BITS_PER_ENTRY, 5'd9));
      // entries past the palette depth map to zero; one bit carries over
      add_row(word_row('1, 1'b1, 8'sd7, 16'h0000));
      add_row(word_row(64'h0, 1'b0, PREDICT, '0));
      // drop the carry by changing the width mid section
      add_row(csr_row(ppu_pkg::REG_BITS_PER_ENTRY, 5'd7));
      add_row(word_row(64'h0, 1'b0, PREDICT, '0));
      add_row(csr_row(ppu_pkg::REG_PALETTE_ENABLE, 5'd0));
      add_row(csr_row(ppu_pkg::REG_BITS_PER_ENTRY, 5'd16));
      add_row(word_row(64'hFFFF_0000_8001_7FFE, 1'b1, PREDICT, '0));
      add_row(word_row('1, 1'b1, 8'sd4, 16'hFFFF));
      add_row(csr_row(ppu_pkg::REG_BITS_PER_ENTRY, 5'd0));
      add_row(word_row(64'hAAAA_AAAA_5555_5555, 1'b1, PREDICT, '0));
      add_row(csr_row(ppu_pkg::REG_BITS_PER_ENTRY, 5'd31));
      add_row(word_row(64'h0, 1'b1, 8'sd4, 16'h0000));

      set_idling(0, 0);
      foreach (stim_rows[i]) begin
         if (stim_rows[i].op == ROW_CSR)
            write_csr(stim_rows[i].csr_idx, stim_rows[i].csr_val);
         else
            send_item(stim_rows[i].kind, stim_rows[i].pidx, stim_rows[i].pval,
                      stim_rows[i].word, stim_rows[i].start, stim_rows[i].typed_n,
                      stim_rows[i].typed_state);
      end

      // fill the whole palette so no entry is read before it is written
      set_idling(11, 11);
      for (int i = 0; i < PAL_DEPTH; i++) send_pal(8'(i), 16'($urandom));

      for (int r = 0; r < 8; r++) begin
         case (r % 4)
            0: set_idling(0, 0);
            1: set_idling(51, 0);
            2: set_idling(0, 51);
            default: set_idling(11, 11);
         endcase
         case (r)
            0: width_pick = 5'd1;
            1: width_pick = 5'd16;
            2: width_pick = 5'd0;
            3: width_pick = 5'd31;
            default: width_pick = 5'($urandom_range(2, 15));
         endcase
         write_csr(ppu_pkg::REG_BITS_PER_ENTRY, width_pick);
         write_csr(ppu_pkg::REG_PALETTE_ENABLE, 5'($urandom_range(0, 1)));
         for (int k = 0; k < 6; k++) begin
            if (k == 3) wait_drained(0);
            pick = $urandom_range(0, 99);
            if (pick < 15) send_pal(8'($urandom), 16'($urandom));
            else if (pick < 20) send_data('0, 1'($urandom));
            else if (pick < 25) send_data('1, 1'($urandom));
            else send_data({$urandom, $urandom}, $urandom_range(0, 9) == 0);
         end
      end

      // run one section to its end, stopping mid word
      set_idling(11, 11);
      write_csr(ppu_pkg::REG_PALETTE_ENABLE, 5'($urandom_range(0, 1)));
      write_csr(ppu_pkg::REG_BITS_PER_ENTRY, 5'd3);
      send_data({$urandom, $urandom}, 1'b1);
      write_csr(ppu_pkg::REG_BITS_PER_ENTRY, 5'd1);
      repeat (66) send_data({$urandom, $urandom}, 1'b0);
      send_data({$urandom, $urandom}, 1'b1);

      wait_drained(SETTLE);
      $display("Summary: %0d items sent (%0d data words, %0d palette writes)",
               items_sent, data_words, pal_writes);
      $display("Summary: %0d entries checked over widths 1..16, palette on and off",
               entries_checked);
      if (mismatches == 0 && pending_entries.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
